// ----- hdl/dve_pkg.sv -----
// Shared types, constants and calendar tables for the date check and elapsed-time block.
`default_nettype none

package dve_pkg;

  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned DAYS_W     = 16;
  localparam int unsigned MONTHS_W   = 12;
  localparam int unsigned DNUM_W     = 21;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Division by 100 as a multiply by a scaled reciprocal, exact for inputs below 8192.
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [12:0] RECIP_100   = 13'd5243;

  localparam logic [YEAR_W-1:0]  MIN_YEAR      = 12'd1900;
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY     = 5'd1;
  localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;

  localparam logic [YEAR_W-1:0]  RST_YEAR  = 12'd2000;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_YEAR    = 3'd0,
    REG_REF_MONTH   = 3'd1,
    REG_REF_DAY     = 3'd2,
    REG_TODAY_YEAR  = 3'd3,
    REG_TODAY_MONTH = 3'd4,
    REG_TODAY_DAY   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  probe_year;
    logic [MONTH_W-1:0] probe_month;
    logic [DAY_W-1:0]   probe_day;
  } in_req_t;

  typedef struct packed {
    logic                date_ok;
    logic [DAYS_W-1:0]   days_elapsed;
    logic [MONTHS_W-1:0] months_elapsed;
  } out_req_t;

  // Load enables of the two pipeline stages inside the day-number unit.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // Days in the year before the first of the month; months past December count as a full year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? LEAP_FEB_DAYS : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dve_daynum.sv -----
// Two-stage pipelined proleptic Gregorian day-number unit with leap-year flag.
`default_nettype none

module dve_daynum (
  input  logic                           clk,
  input  dve_pkg::stage_en_t             en,
  input  logic [dve_pkg::YEAR_W-1:0]     year,
  input  logic [dve_pkg::MONTH_W-1:0]    month,
  input  logic [dve_pkg::DAY_W-1:0]      day,
  output logic [dve_pkg::DNUM_W-1:0]     day_num,
  output logic                           leap
);

  logic [dve_pkg::YEAR_W-1:0]  year_r;
  logic [dve_pkg::MONTH_W-1:0] month_r;
  logic [dve_pkg::DAY_W-1:0]   day_r;
  logic [6:0]                  cent_r, cent_nxt;
  logic [3:0]                  quad_r, quad_nxt;
  logic [dve_pkg::DNUM_W-1:0]  day_num_r, day_num_nxt;
  logic                        leap_r, leap_nxt;

  logic [12:0] year_p99, year_p399, year_p3;
  logic [25:0] cent_prod;
  logic [23:0] quad_prod;
  logic        div4, div100, div400;
  logic [dve_pkg::DNUM_W-1:0] leaps;

  // Stage 1: ceil(y/100) and ceil(y/400) by reciprocal multiplication.
  always_comb begin
    year_p99  = 13'(year) + 13'd99;
    year_p399 = 13'(year) + 13'd399;
    cent_prod = 26'(year_p99) * 26'(dve_pkg::RECIP_100);
    quad_prod = 24'(year_p399[12:2]) * 24'(dve_pkg::RECIP_100);
    cent_nxt  = cent_prod[dve_pkg::RECIP_SHIFT +: 7];
    quad_nxt  = quad_prod[dve_pkg::RECIP_SHIFT +: 4];
  end

  // Stage 2: a year is a multiple of 100 exactly when it equals 100 * ceil(y/100).
  always_comb begin
    year_p3     = 13'(year_r) + 13'd3;
    div4        = (year_r[1:0] == 2'b00);
    div100      = (13'(year_r) == 13'(cent_r) * 13'd100);
    div400      = (13'(year_r) == 13'(quad_r) * 13'd400);
    leap_nxt    = div4 && (!div100 || div400);
    leaps       = 21'(year_p3[12:2]) - 21'(cent_r) + 21'(quad_r);
    day_num_nxt = 21'(year_r) * 21'd365 + leaps
                + 21'(dve_pkg::days_before(month_r)) + 21'(day_r)
                + 21'((month_r > dve_pkg::MONTH_FEB) && leap_nxt);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      year_r  <= year;
      month_r <= month;
      day_r   <= day;
      cent_r  <= cent_nxt;
      quad_r  <= quad_nxt;
    end
    if (en.s2) begin
      day_num_r <= day_num_nxt;
      leap_r    <= leap_nxt;
    end
  end

  assign day_num = day_num_r;
  assign leap    = leap_r;

endmodule

`default_nettype wire

// ----- hdl/date_validate_and_elapsed_top.sv -----
// Top level: pipelined Gregorian date check with days and months elapsed against a reference.
//
//   Port group  Direction  Handshake          Payload
//   in_         request in  in_valid/in_ready  dve_pkg::in_req_t
//   out_        result out  out_valid/out_ready dve_pkg::out_req_t
//   cfg_        write in    cfg_we             cfg_index, cfg_wdata
//
// One request is accepted per cycle while in_ready is high; via the stage 1 and 2 registers
// its result reaches the output register and can be taken at the following edge at earliest.
// Three register stages: reciprocal divides, day numbers, then difference and clamp.
// Each full stage holds while the one after it is full and stalled, so bubbles close up and a
// stalled result never blocks a free input stage. Reset is synchronous and empties the pipe.
`default_nettype none

module date_validate_and_elapsed_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dve_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dve_pkg::out_req_t                   out_data,
  input  logic                                cfg_we,
  input  logic [dve_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dve_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef struct packed {
    logic                        pre_ok;
    logic [dve_pkg::MONTH_W-1:0] month;
    logic [dve_pkg::DAY_W-1:0]   day;
    logic [12:0]                 dy;
    logic [5:0]                  dm;
  } st1_t;

  typedef struct packed {
    logic                         pre_ok;
    logic [dve_pkg::MONTH_W-1:0]  month;
    logic [dve_pkg::DAY_W-1:0]    day;
    logic [dve_pkg::MONTHS_W-1:0] months;
  } st2_t;

  logic [dve_pkg::YEAR_W-1:0]  ref_year_r, today_year_r;
  logic [dve_pkg::MONTH_W-1:0] ref_month_r, today_month_r;
  logic [dve_pkg::DAY_W-1:0]   ref_day_r, today_day_r;

  logic v1_r, v1_nxt, v2_r, v2_nxt, out_valid_r, out_valid_nxt;
  dve_pkg::stage_en_t en;
  logic en3;

  st1_t st1_r, st1_nxt;
  st2_t st2_r, st2_nxt;
  dve_pkg::out_req_t out_r, out_nxt;

  logic [dve_pkg::DNUM_W-1:0] probe_dn, ref_dn, dn_diff;
  logic                       probe_leap, ref_leap;
  logic                       not_future;
  logic signed [17:0]         mo_full;

  // Ready ripples back from the output register through each stage.
  always_comb begin
    en3           = !out_valid_r || out_ready;
    en.s2         = !v2_r || en3;
    en.s1         = !v1_r || en.s2;
    v1_nxt        = en.s1 ? in_valid : v1_r;
    v2_nxt        = en.s2 ? v1_r : v2_r;
    out_valid_nxt = en3 ? v2_r : out_valid_r;
  end

  assign in_ready  = en.s1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      ref_year_r    <= dve_pkg::RST_YEAR;
      ref_month_r   <= dve_pkg::RST_MONTH;
      ref_day_r     <= dve_pkg::RST_DAY;
      today_year_r  <= dve_pkg::RST_YEAR;
      today_month_r <= dve_pkg::RST_MONTH;
      today_day_r   <= dve_pkg::RST_DAY;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (dve_pkg::cfg_reg_t'(cfg_index))
          dve_pkg::REG_REF_YEAR:    ref_year_r    <= cfg_wdata[dve_pkg::YEAR_W-1:0];
          dve_pkg::REG_REF_MONTH:   ref_month_r   <= cfg_wdata[dve_pkg::MONTH_W-1:0];
          dve_pkg::REG_REF_DAY:     ref_day_r     <= cfg_wdata[dve_pkg::DAY_W-1:0];
          dve_pkg::REG_TODAY_YEAR:  today_year_r  <= cfg_wdata[dve_pkg::YEAR_W-1:0];
          dve_pkg::REG_TODAY_MONTH: today_month_r <= cfg_wdata[dve_pkg::MONTH_W-1:0];
          dve_pkg::REG_TODAY_DAY:   today_day_r   <= cfg_wdata[dve_pkg::DAY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Stage 1: range checks that do not need the leap flag, and the raw month distance.
  always_comb begin
    if (in_data.probe_year < today_year_r) begin
      not_future = 1'b1;
    end else if (in_data.probe_month < today_month_r) begin
      not_future = 1'b1;
    end else begin
      not_future = (in_data.probe_month == today_month_r) &&
                   (in_data.probe_day <= today_day_r);
    end
    st1_nxt.pre_ok = (in_data.probe_year >= dve_pkg::MIN_YEAR) &&
                     (in_data.probe_year <= today_year_r) &&
                     (in_data.probe_month >= dve_pkg::MONTH_JAN) &&
                     (in_data.probe_month <= dve_pkg::MONTH_DEC) &&
                     (in_data.probe_day >= dve_pkg::FIRST_DAY) && not_future;
    st1_nxt.month  = in_data.probe_month;
    st1_nxt.day    = in_data.probe_day;
    st1_nxt.dy     = 13'(in_data.probe_year) - 13'(ref_year_r);
    // A reference day past the probe day leaves the last month incomplete.
    st1_nxt.dm     = 6'(in_data.probe_month) - 6'(ref_month_r)
                   - 6'(ref_day_r > in_data.probe_day);
  end

  // Stage 2: month count in signed form, clamped to the field range.
  always_comb begin
    mo_full = 18'($signed(st1_r.dy)) * 18'sd12 + 18'($signed(st1_r.dm));
    st2_nxt.pre_ok = st1_r.pre_ok;
    st2_nxt.month  = st1_r.month;
    st2_nxt.day    = st1_r.day;
    if (mo_full[17]) begin
      st2_nxt.months = '0;
    end else if (mo_full[16:12] != 5'd0) begin
      st2_nxt.months = '1;
    end else begin
      st2_nxt.months = mo_full[11:0];
    end
  end

  // Stage 3: month length check and saturated day difference.
  always_comb begin
    dn_diff         = ref_dn - probe_dn;
    out_nxt.date_ok = st2_r.pre_ok &&
                      (st2_r.day <= dve_pkg::month_len(st2_r.month, probe_leap));
    if (!out_nxt.date_ok || (ref_dn < probe_dn)) begin
      out_nxt.days_elapsed = '0;
    end else if (dn_diff[20:16] != 5'd0) begin
      out_nxt.days_elapsed = '1;
    end else begin
      out_nxt.days_elapsed = dn_diff[15:0];
    end
    out_nxt.months_elapsed = out_nxt.date_ok ? st2_r.months : '0;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      st1_r <= st1_nxt;
    end
    if (en.s2) begin
      st2_r <= st2_nxt;
    end
    if (en3) begin
      out_r <= out_nxt;
    end
  end

  dve_daynum u_probe_dn (
    .clk     (clk),
    .en      (en),
    .year    (in_data.probe_year),
    .month   (in_data.probe_month),
    .day     (in_data.probe_day),
    .day_num (probe_dn),
    .leap    (probe_leap)
  );

  // Keep the reference static while requests are in flight (not enforced); it rides the same pipeline.
  dve_daynum u_ref_dn (
    .clk     (clk),
    .en      (en),
    .year    (ref_year_r),
    .month   (ref_month_r),
    .day     (ref_day_r),
    .day_num (ref_dn),
    .leap    (ref_leap)
  );

  // The reference leap flag is already folded into its day number.
  logic unused_ref_leap;
  assign unused_ref_leap = ref_leap;

endmodule

`default_nettype wire

// ----- hdl/dve_checker.sv -----
// Port-level checker for the date check block, bound to the top level.
`default_nettype none

module dve_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input dve_pkg::out_req_t              out_data
);

  // A held result keeps its contents until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A rejected date carries no elapsed counts.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.date_ok |->
      out_data.days_elapsed == '0 && out_data.months_elapsed == '0)
    else $error("invalid date reported nonzero elapsed time");

  // With the output register empty every stage can move, so a request is always taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // With the output empty, a result can only show up next if a request taken earlier has
  // passed unstalled through stage 1 and stage 2.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && in_ready, 2) && $past(rst_n, 1) && $past(rst_n, 2)
      |=> !out_valid)
    else $error("result appeared without a request two cycles earlier");

endmodule

bind date_validate_and_elapsed_top dve_checker u_dve_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- bench/date_validate_and_elapsed_top_tb.sv -----
// Testbench for the date check and elapsed-time block: a directed table, then random probes.
`timescale 1ns / 1ps

module date_validate_and_elapsed_top_tb;

  localparam int QUIET_LIMIT = 3000;
  localparam logic [dve_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [dve_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_PROBE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [dve_pkg::CFG_IDX_W-1:0]  idx;
    logic [dve_pkg::CFG_DATA_W-1:0] val;
    dve_pkg::in_req_t               probe;
    bit                             typed;
    dve_pkg::out_req_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dve_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dve_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [dve_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dve_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copies of the six registers, as the block should hold them.
  logic [dve_pkg::YEAR_W-1:0]  ref_yr   = dve_pkg::RST_YEAR;
  logic [dve_pkg::MONTH_W-1:0] ref_mo   = dve_pkg::RST_MONTH;
  logic [dve_pkg::DAY_W-1:0]   ref_dy   = dve_pkg::RST_DAY;
  logic [dve_pkg::YEAR_W-1:0]  today_yr = dve_pkg::RST_YEAR;
  logic [dve_pkg::MONTH_W-1:0] today_mo = dve_pkg::RST_MONTH;
  logic [dve_pkg::DAY_W-1:0]   today_dy = dve_pkg::RST_DAY;

  int unsigned days_before_month [0:15] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365};
  int unsigned month_length [0:15] =
    '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0};

  dve_pkg::out_req_t pending_results [$];
  stim_row_t stim_rows [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 83;

  date_validate_and_elapsed_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    if (m == dve_pkg::MONTH_FEB && leap_year(y)) return 32'(dve_pkg::LEAP_FEB_DAYS);
    return month_length[m];
  endfunction

  // Proleptic Gregorian day number; year 0 counts as a leap year.
  function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned n;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + days_before_month[m] + d;
    if (m > dve_pkg::MONTH_FEB && leap_year(y)) n++;
    return n;
  endfunction

  function automatic dve_pkg::out_req_t predict_elapsed(input dve_pkg::in_req_t p);
    int unsigned y, m, d, rn, pn;
    int mo;
    bit ok;
    dve_pkg::out_req_t r;
    y = p.probe_year;
    m = p.probe_month;
    d = p.probe_day;
    r = '0;
    ok = 1'b1;
    if (y < dve_pkg::MIN_YEAR || y > today_yr) ok = 1'b0;
    else if (m < dve_pkg::MONTH_JAN || m > dve_pkg::MONTH_DEC) ok = 1'b0;
    else if (d < dve_pkg::FIRST_DAY || d > month_days(y, m)) ok = 1'b0;
    else if (y == today_yr && (m > today_mo || (m == today_mo && d > today_dy))) ok = 1'b0;
    if (ok) begin
      r.date_ok = 1'b1;
      rn = day_number(ref_yr, ref_mo, ref_dy);
      pn = day_number(y, m, d);
      if (rn >= pn) r.days_elapsed = (rn - pn > 65535) ? 16'hFFFF : 16'(rn - pn);
      mo = (int'(y) - int'(ref_yr)) * 12 + int'(m) - int'(ref_mo);
      if (ref_dy > d) mo--;
      if (mo < 0) mo = 0;
      if (mo > 4095) mo = 4095;
      r.months_elapsed = 12'(mo);
    end
    return r;
  endfunction

  // Real dates up to today's year as the largest share, with some near today or the
  // reference, a few on the calendar boundaries, and the rest raw noise.
  function automatic dve_pkg::in_req_t random_probe();
    dve_pkg::in_req_t p;
    int unsigned sel, yhi;
    sel = $urandom_range(99);
    yhi = (today_yr >= dve_pkg::MIN_YEAR) ? today_yr : dve_pkg::MIN_YEAR;
    p.probe_year = 12'($urandom);
    p.probe_month = 4'($urandom);
    p.probe_day = 5'($urandom);
    if (sel < 40) begin
      p.probe_year = 12'($urandom_range(yhi, dve_pkg::MIN_YEAR));
      p.probe_month = 4'($urandom_range(dve_pkg::MONTH_DEC, dve_pkg::MONTH_JAN));
      p.probe_day = 5'($urandom_range(month_days(p.probe_year, p.probe_month),
                                      dve_pkg::FIRST_DAY));
    end else if (sel < 55) begin
      p.probe_year = today_yr;
      p.probe_month = (today_mo >= dve_pkg::MONTH_JAN && today_mo <= dve_pkg::MONTH_DEC) ?
                      today_mo :
                      4'($urandom_range(dve_pkg::MONTH_DEC, dve_pkg::MONTH_JAN));
      p.probe_day = 5'(today_dy + $urandom_range(2) - 1);
    end else if (sel < 70) begin
      p.probe_year = 12'(ref_yr - $urandom_range(1));
      p.probe_month = 4'(ref_mo + $urandom_range(2) - 1);
      p.probe_day = 5'(ref_dy + $urandom_range(2) - 1);
    end else if (sel < 82) begin
      case ($urandom_range(3))
        0: p.probe_year = 12'(dve_pkg::MIN_YEAR - 1);
        1: p.probe_year = dve_pkg::MIN_YEAR;
        2: p.probe_year = today_yr;
        default: p.probe_year = 12'(today_yr + 1);
      endcase
      case ($urandom_range(4))
        0: p.probe_month = 4'd0;
        1: p.probe_month = dve_pkg::MONTH_JAN;
        2: p.probe_month = dve_pkg::MONTH_FEB;
        3: p.probe_month = dve_pkg::MONTH_DEC;
        default: p.probe_month = 4'(dve_pkg::MONTH_DEC + 1);
      endcase
      case ($urandom_range(5))
        0: p.probe_day = 5'd0;
        1: p.probe_day = dve_pkg::FIRST_DAY;
        2: p.probe_day = 5'd28;
        3: p.probe_day = dve_pkg::LEAP_FEB_DAYS;
        4: p.probe_day = 5'd30;
        default: p.probe_day = 5'd31;
      endcase
    end
    return p;
  endfunction

  function automatic stim_row_t probe_row(input int y, input int m, input int d);
    stim_row_t r;
    r.kind = ROW_PROBE;
    r.idx = '0;
    r.val = '0;
    r.probe.probe_year = 12'(y);
    r.probe.probe_month = 4'(m);
    r.probe.probe_day = 5'(d);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input int y, input int m, input int d,
                                          input bit ok, input int days, input int months);
    stim_row_t r;
    r = probe_row(y, m, d);
    r.typed = 1'b1;
    r.want.date_ok = ok;
    r.want.days_elapsed = 16'(days);
    r.want.months_elapsed = 12'(months);
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [dve_pkg::CFG_IDX_W-1:0] idx,
                                        input int val);
    stim_row_t r;
    r = probe_row(0, 0, 0);
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = 12'(val);
    return r;
  endfunction

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Present one request, with a random gap before it, and hold it until it is taken.
  task automatic send_probe(input dve_pkg::in_req_t p, input bit typed,
                            input dve_pkg::out_req_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? want : predict_elapsed(p));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dve_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dve_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      dve_pkg::REG_REF_YEAR:    ref_yr = val;
      dve_pkg::REG_REF_MONTH:   ref_mo = val[dve_pkg::MONTH_W-1:0];
      dve_pkg::REG_REF_DAY:     ref_dy = val[dve_pkg::DAY_W-1:0];
      dve_pkg::REG_TODAY_YEAR:  today_yr = val;
      dve_pkg::REG_TODAY_MONTH: today_mo = val[dve_pkg::MONTH_W-1:0];
      dve_pkg::REG_TODAY_DAY:   today_dy = val[dve_pkg::DAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int unsigned ry, input int unsigned rm, input int unsigned rd,
                              input int unsigned ty, input int unsigned tm, input int unsigned td);
    wait_drain();
    write_reg(dve_pkg::REG_REF_YEAR, 12'(ry));
    write_reg(dve_pkg::REG_REF_MONTH, 12'(rm));
    write_reg(dve_pkg::REG_REF_DAY, 12'(rd));
    write_reg(dve_pkg::REG_TODAY_YEAR, 12'(ty));
    write_reg(dve_pkg::REG_TODAY_MONTH, 12'(tm));
    write_reg(dve_pkg::REG_TODAY_DAY, 12'(td));
    write_reg(REG_SPARE_HI, 12'($urandom));
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      // Halfway through, hold off new requests until the pipe has emptied.
      if (n == count / 2) wait_drain();
      send_probe(random_probe(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    dve_pkg::out_req_t want;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("result with no request pending", 0, 32'(out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.date_ok !== want.date_ok)
          report("date_ok", want.date_ok, out_data.date_ok);
        if (out_data.days_elapsed !== want.days_elapsed)
          report("days_elapsed", want.days_elapsed, out_data.days_elapsed);
        if (out_data.months_elapsed !== want.months_elapsed)
          report("months_elapsed", want.months_elapsed, out_data.months_elapsed);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit idle_now;
    idle_now = 1'b1;

    // Reference and today both at reset: 2000-01-01.
    stim_rows.push_back(known_row(2000, 1, 1, 1, 0, 0));
    stim_rows.push_back(known_row(1900, 1, 1, 1, 36524, 0));
    stim_rows.push_back(known_row(1999, 12, 31, 1, 1, 0));
    stim_rows.push_back(known_row(2000, 1, 2, 0, 0, 0));
    stim_rows.push_back(known_row(1899, 12, 31, 0, 0, 0));
    stim_rows.push_back(known_row(0, 0, 0, 0, 0, 0));
    stim_rows.push_back(known_row(4095, 15, 31, 0, 0, 0));
    stim_rows.push_back(known_row(1950, 13, 10, 0, 0, 0));
    stim_rows.push_back(known_row(1950, 4, 31, 0, 0, 0));
    stim_rows.push_back(known_row(1900, 2, 29, 0, 0, 0));
    stim_rows.push_back(probe_row(1996, 2, 29));
    stim_rows.push_back(known_row(1995, 2, 29, 0, 0, 0));
    stim_rows.push_back(probe_row(1972, 7, 15));
    stim_rows.push_back(probe_row(1999, 1, 31));
    // Reference at the calendar minimum, today far later; a probe after the reference gives zero days.
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_YEAR, 1900));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_YEAR, 2155));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_MONTH, 12));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_DAY, 31));
    stim_rows.push_back(known_row(2155, 12, 31, 1, 0, 3071));
    stim_rows.push_back(known_row(1900, 1, 1, 1, 0, 0));
    stim_rows.push_back(probe_row(2024, 2, 29));
    // Reference at the far end: the day count saturates.
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_YEAR, 2155));
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_MONTH, 12));
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_DAY, 31));
    stim_rows.push_back(known_row(1900, 1, 1, 1, 65535, 0));
    stim_rows.push_back(probe_row(2100, 3, 1));
    stim_rows.push_back(known_row(2100, 2, 29, 0, 0, 0));
    // Reference at year zero, month zero, day zero; today past the calendar.
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_YEAR, 0));
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_MONTH, 0));
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_DAY, 0));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_YEAR, 4095));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_MONTH, 15));
    stim_rows.push_back(reg_row(REG_SPARE_LO, 4095));
    stim_rows.push_back(reg_row(REG_SPARE_HI, 0));
    stim_rows.push_back(known_row(4095, 12, 31, 1, 0, 4095));
    // Reference month past December, and a today with day zero.
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_YEAR, 2000));
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_MONTH, 14));
    stim_rows.push_back(reg_row(dve_pkg::REG_REF_DAY, 31));
    stim_rows.push_back(probe_row(2000, 12, 31));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_YEAR, 2000));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_MONTH, 6));
    stim_rows.push_back(reg_row(dve_pkg::REG_TODAY_DAY, 0));
    stim_rows.push_back(known_row(2000, 6, 1, 0, 0, 0));
    stim_rows.push_back(probe_row(2000, 5, 31));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        if (!idle_now) wait_drain();
        idle_now = 1'b1;
        write_reg(stim_rows[i].idx, stim_rows[i].val);
      end else begin
        send_probe(stim_rows[i].probe, stim_rows[i].typed, stim_rows[i].want);
        idle_now = 1'b0;
      end
    end

    apply_config(2000, 1, 1, 2000, 1, 1);
    run_random(120);
    apply_config(1900, 1, 1, 2155, 12, 31);
    run_random(150);
    apply_config(2155, 12, 31, 2155, 12, 31);
    run_random(100);

    send_idle_pct = 83;
    recv_idle_pct = 10;
    apply_config(2024, 3, 31, 2024, 2, 29);
    run_random(150);
    apply_config(0, 0, 0, 4095, 15, 31);
    run_random(100);
    apply_config(4095, 15, 31, 1900, 1, 1);
    run_random(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) begin
      apply_config($urandom_range(2155, 1900), $urandom_range(12, 1), $urandom_range(31, 1),
                   $urandom_range(2155, 1900), $urandom_range(12, 1), $urandom_range(31, 1));
      run_random(150);
    end
    apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(100);

    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dve_pkg.sv
hdl/dve_daynum.sv
hdl/date_validate_and_elapsed_top.sv
hdl/dve_checker.sv
bench/date_validate_and_elapsed_top_tb.sv
